@@ design/pfx_pkg.sv @@
// Package for the prefix-code bit packer.
// Holds operation codes, shared widths and the controller/datapath command and status types.
// No dependencies.
package pfx_pkg;

  localparam int unsigned MAX_CODE_LEN_DEF = 32;
  localparam int unsigned CODE_WORD_BITS = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TBL_DEPTH = 256;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned OP_W = 2;
  localparam int unsigned LEN_IN_W = 6;
  localparam int unsigned PEND_W = BYTE_W - 1;
  localparam int unsigned PCNT_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic flush;
    logic merge;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic merge_emits;
    logic flush_emits;
    logic emit_last;
    logic slot_free;
  } status_t;

endpackage

@@ design/pfx_ctrl.sv @@
// Controller state machine of the prefix-code bit packer.
// Sequences table loads, lookups, flushes and byte emission; depends on pfx_pkg.
module pfx_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [pfx_pkg::OP_W-1:0]   in_op,
  output logic                       in_stall,
  input  pfx_pkg::status_t           sts,
  output pfx_pkg::cmd_t              cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOKUP = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_stall = (state_r != ST_IDLE);
  assign acc      = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (pfx_pkg::op_t'(in_op))
            pfx_pkg::OP_LOAD: begin
              cmd.wr_en = 1'b1;
            end
            pfx_pkg::OP_ENCODE: begin
              cmd.rd_en = 1'b1;
              state_nxt = ST_LOOKUP;
            end
            pfx_pkg::OP_FLUSH: begin
              cmd.flush = 1'b1;
              if (sts.flush_emits) begin
                state_nxt = ST_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        cmd.merge = 1'b1;
        state_nxt = sts.merge_emits ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/pfx_dp.sv @@
// Datapath of the prefix-code bit packer.
// Holds the code table memory, the bit accumulator and the output register; depends on pfx_pkg.
module pfx_dp #(
  parameter int unsigned MAX_CODE_LEN = pfx_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [pfx_pkg::SYM_W-1:0]      in_symbol,
  input  logic [pfx_pkg::LEN_IN_W-1:0]   in_code_len,
  input  logic [31:0]                    in_code_bits,
  input  pfx_pkg::cmd_t                  cmd,
  output pfx_pkg::status_t               sts,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pfx_pkg::BYTE_W-1:0]     out_byte,
  output logic                           out_last
);

  localparam int unsigned CAP = (MAX_CODE_LEN < pfx_pkg::CODE_WORD_BITS) ?
                                MAX_CODE_LEN : pfx_pkg::CODE_WORD_BITS;
  localparam int unsigned LEN_W = $clog2(CAP + 1);
  localparam int unsigned ENT_W = LEN_W + CAP;
  localparam int unsigned ACC_W = CAP + pfx_pkg::PEND_W;
  localparam int unsigned TOT_W = $clog2(CAP + pfx_pkg::BYTE_W);
  localparam int unsigned BW = pfx_pkg::BYTE_W;

  logic [ENT_W-1:0]              tbl_mem_r [pfx_pkg::TBL_DEPTH];
  logic [pfx_pkg::TBL_DEPTH-1:0] tbl_vld_r;
  logic [ENT_W-1:0]              rd_ent_r;
  logic                          rd_vld_r;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [TOT_W-1:0] tot_r, tot_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [BW-1:0]    out_byte_r;
  logic             out_last_r;

  logic [LEN_W-1:0]           wr_len;
  logic [CAP-1:0]             wr_bits;
  logic [CAP-1:0]             wr_mask;
  logic [LEN_W-1:0]           rd_len;
  logic [CAP-1:0]             rd_bits;
  logic [pfx_pkg::PCNT_W-1:0] pend_cnt;
  logic [pfx_pkg::PEND_W-1:0] pend_bits;
  logic [ACC_W-1:0]           acc_m;
  logic [TOT_W-1:0]           tot_m;
  logic [BW-1:0]              flush_byte;
  logic [TOT_W-1:0]           tot_e;
  logic [BW-1:0]              emit_byte;

  // Length saturation and masking of code bits above the stored length.
  always_comb begin
    if (in_code_len > pfx_pkg::LEN_IN_W'(CAP)) begin
      wr_len = LEN_W'(CAP);
    end else begin
      wr_len = LEN_W'(in_code_len);
    end
    wr_mask = ~({CAP{1'b1}} << wr_len);
    if (wr_len == LEN_W'(CAP)) begin
      wr_mask = {CAP{1'b1}};
    end
    wr_bits = CAP'(in_code_bits) & wr_mask;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      tbl_mem_r[in_symbol] <= {wr_len, wr_bits};
    end
    if (cmd.rd_en) begin
      rd_ent_r <= tbl_mem_r[in_symbol];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        tbl_vld_r[in_symbol] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld_r <= tbl_vld_r[in_symbol];
      end
    end
  end

  assign rd_len  = rd_vld_r ? rd_ent_r[ENT_W-1:CAP] : '0;
  assign rd_bits = rd_vld_r ? rd_ent_r[CAP-1:0] : '0;

  // Between items the accumulator holds fewer than eight pending bits.
  assign pend_cnt  = tot_r[pfx_pkg::PCNT_W-1:0];
  assign pend_bits = acc_r[pfx_pkg::PEND_W-1:0] &
                     ~({pfx_pkg::PEND_W{1'b1}} << pend_cnt);

  assign acc_m = (ACC_W'(pend_bits) << rd_len) | ACC_W'(rd_bits);
  assign tot_m = TOT_W'(pend_cnt) + TOT_W'(rd_len);

  assign flush_byte = BW'({1'b0, pend_bits} << (4'(BW) - {1'b0, pend_cnt}));

  assign tot_e     = tot_r - TOT_W'(BW);
  assign emit_byte = BW'(acc_r >> tot_e);

  always_comb begin
    acc_nxt = acc_r;
    tot_nxt = tot_r;
    if (cmd.merge) begin
      acc_nxt = acc_m;
      tot_nxt = tot_m;
    end else if (cmd.flush) begin
      acc_nxt = ACC_W'(flush_byte);
      tot_nxt = (pend_cnt != '0) ? TOT_W'(BW) : '0;
    end else if (cmd.emit) begin
      tot_nxt = tot_e;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.emit) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      tot_r     <= tot_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= (tot_e < TOT_W'(BW));
    end
  end

  assign sts.merge_emits = (tot_m >= TOT_W'(BW));
  assign sts.flush_emits = (pend_cnt != '0);
  assign sts.emit_last   = (tot_e < TOT_W'(BW));
  assign sts.slot_free   = !out_vld_r || !out_stall;

  assign out_valid = out_vld_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

@@ design/prefix_code_bit_packer.sv @@
// Prefix-code bit packer: a 256-entry code table is loaded with op 0 items, op 1 items
// append the code of their symbol to a pending bit stream and emit each complete byte
// earliest bit first, and op 2 flushes the leftover bits as one zero-padded byte. One
// item is handled at a time. An encode does a registered table read and then a merge,
// and emits zero to four bytes, each waiting while the output is stalled; a flush with
// pending bits emits its byte after the flush. The single-byte output register may hold
// the last byte of an item while the next item is already accepted. out_last marks the
// final byte of each item. The code table is ready right after reset; its valid bits
// clear at once.
module prefix_code_bit_packer #(
  parameter int unsigned MAX_CODE_LEN = pfx_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pfx_pkg::OP_W-1:0]       in_op,
  input  logic [pfx_pkg::SYM_W-1:0]      in_symbol,
  input  logic [pfx_pkg::LEN_IN_W-1:0]   in_code_len,
  input  logic [31:0]                    in_code_bits,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pfx_pkg::BYTE_W-1:0]     out_byte,
  output logic                           out_last
);

  pfx_pkg::cmd_t    cmd;
  pfx_pkg::status_t sts;

  pfx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfx_dp #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_symbol    (in_symbol),
    .in_code_len  (in_code_len),
    .in_code_bits (in_code_bits),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

endmodule

@@ design/pfx_chk.sv @@
// Port-level checker for the prefix-code bit packer, bound to the top level.
// Depends on pfx_pkg for the operation codes.
module pfx_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [pfx_pkg::OP_W-1:0]       in_op,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [pfx_pkg::BYTE_W-1:0]     out_byte,
  input logic                           out_last
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output changed");

  // While an item still has bytes to deliver, no new item is taken.
  a_busy_while_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input accepted before the last byte of an item");

  // After an encode is taken, the input always stalls for its table lookup.
  a_lookup_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == pfx_pkg::OP_ENCODE) |=> in_stall)
    else $error("encode did not stall for the lookup");

  // A table load never produces a new result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == pfx_pkg::OP_LOAD)
      |=> !(out_valid && !$past(out_valid && out_stall)))
    else $error("table load produced output");

endmodule

bind prefix_code_bit_packer pfx_chk u_pfx_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_op     (in_op),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_last  (out_last)
);

@@ bench/prefix_code_bit_packer_tb.sv @@
// Self-checking testbench for prefix_code_bit_packer: a directed table, then random
// table loads, encodes, flushes and no-ops under varied sender and receiver idling.
// Depends on pfx_pkg and the prefix_code_bit_packer RTL.
`timescale 1ns / 100ps

module prefix_code_bit_packer_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_ROWS = 26;
  localparam int RAND_ITEMS = 370;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    pfx_pkg::op_t op;
    logic [7:0]   sym;
    logic [5:0]   len;
    logic [31:0]  bits;
    int           nres;
    logic [31:0]  bytes;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] val;
    logic       last;
  } packed_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = pfx_pkg::OP_NONE;
  logic [7:0]  in_symbol = '0;
  logic [5:0]  in_code_len = '0;
  logic [31:0] in_code_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  logic [5:0]  code_len_tbl [256];
  logic [31:0] code_word_tbl [256];
  logic [6:0]  held_bits;
  logic [2:0]  held_cnt;
  logic [7:0]  sym_pool [16];

  packed_byte_t byte_queue [$];

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{pfx_pkg::OP_FLUSH,  8'h00, 6'd0,  32'h0,        0, 32'h0},
    '{pfx_pkg::OP_ENCODE, 8'h00, 6'd0,  32'h0,        0, 32'h0},
    '{pfx_pkg::OP_NONE,   8'hFF, 6'd63, 32'hFFFFFFFF, 0, 32'h0},
    '{pfx_pkg::OP_LOAD,   8'h41, 6'd8,  32'h000000A5, 0, 32'h0},
    '{pfx_pkg::OP_ENCODE, 8'h41, 6'd0,  32'h0,        1, 32'h000000A5},
    '{pfx_pkg::OP_LOAD,   8'hFF, 6'd32, 32'hFFFFFFFF, 0, 32'h0},
    '{pfx_pkg::OP_ENCODE, 8'hFF, 6'd0,  32'h0,        4, 32'hFFFFFFFF},
    '{pfx_pkg::OP_LOAD,   8'h00, 6'd63, 32'h12345678, 0, 32'h0},
    '{pfx_pkg::OP_ENCODE, 8'h00, 6'd0,  32'h0,        4, 32'h12345678},
    '{pfx_pkg::OP_LOAD,   8'h01, 6'd1,  32'hFFFFFFFF, 0, 32'h0},
    '{pfx_pkg::OP_ENCODE, 8'h01, 6'd0,  32'h0,        0, 32'h0},
    '{pfx_pkg::OP_FLUSH,  8'h00, 6'd0,  32'h0,        1, 32'h00000080},
    '{pfx_pkg::OP_LOAD,   8'h02, 6'd3,  32'h00000005, 0, 32'h0},
    '{pfx_pkg::OP_ENCODE, 8'h02, 6'd0,  32'h0,        0, 32'h0},
    '{pfx_pkg::OP_ENCODE, 8'h02, 6'd0,  32'h0,        0, 32'h0},
    '{pfx_pkg::OP_ENCODE, 8'hFF, 6'd0,  32'h0,       -1, 32'h0},
    '{pfx_pkg::OP_FLUSH,  8'h00, 6'd0,  32'h0,       -1, 32'h0},
    '{pfx_pkg::OP_LOAD,   8'h01, 6'd0,  32'h0000FFFF, 0, 32'h0},
    '{pfx_pkg::OP_ENCODE, 8'h01, 6'd0,  32'h0,        0, 32'h0},
    '{pfx_pkg::OP_LOAD,   8'h80, 6'd7,  32'h00000055, 0, 32'h0},
    '{pfx_pkg::OP_ENCODE, 8'h80, 6'd0,  32'h0,        0, 32'h0},
    '{pfx_pkg::OP_ENCODE, 8'h80, 6'd0,  32'h0,       -1, 32'h0},
    '{pfx_pkg::OP_NONE,   8'h80, 6'd63, 32'hFFFFFFFF, 0, 32'h0},
    '{pfx_pkg::OP_FLUSH,  8'h00, 6'd0,  32'h0,       -1, 32'h0},
    '{pfx_pkg::OP_LOAD,   8'h10, 6'd33, 32'h80000001, 0, 32'h0},
    '{pfx_pkg::OP_ENCODE, 8'h10, 6'd0,  32'h0,       -1, 32'h0}
  };

  prefix_code_bit_packer dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_symbol    (in_symbol),
    .in_code_len  (in_code_len),
    .in_code_bits (in_code_bits),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    mismatch_cnt++;
  endtask

  // Computes the bytes one transfer produces and advances the packing state.
  task automatic pack_symbol(input pfx_pkg::op_t op, input logic [7:0] sym,
                             input logic [5:0] len_in, input logic [31:0] bits_in,
                             output int n, output logic [7:0] res [4]);
    int          len;
    int          total;
    logic [63:0] acc;
    logic [15:0] padded;
    n = 0;
    for (int k = 0; k < 4; k++) res[k] = '0;
    case (op)
      pfx_pkg::OP_LOAD: begin
        len = (len_in > 32) ? 32 : int'(len_in);
        code_len_tbl[sym] = 6'(len);
        code_word_tbl[sym] = 32'(64'(bits_in) & ((64'd1 << len) - 64'd1));
      end
      pfx_pkg::OP_ENCODE: begin
        len = int'(code_len_tbl[sym]);
        if (len != 0) begin
          acc = (64'(held_bits) << len) | 64'(code_word_tbl[sym]);
          total = int'(held_cnt) + len;
          while (total >= 8 && n < 4) begin
            res[n] = 8'(acc >> (total - 8));
            total -= 8;
            n++;
          end
          held_bits = 7'(acc & ((64'd1 << total) - 64'd1));
          held_cnt = 3'(total);
        end
      end
      pfx_pkg::OP_FLUSH: begin
        if (held_cnt != 0) begin
          padded = 16'(held_bits) << (8 - int'(held_cnt));
          res[0] = padded[7:0];
          n = 1;
          held_bits = '0;
          held_cnt = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_bytes(input int n, input logic [7:0] res [4]);
    for (int k = 0; k < n; k++) byte_queue.push_back('{val: res[k], last: (k == n - 1)});
  endtask

  // Drives one transfer; nres >= 0 supplies typed bytes in place of the predicted ones.
  task automatic send_item(input pfx_pkg::op_t op, input logic [7:0] sym,
                           input logic [5:0] len, input logic [31:0] bits,
                           input int nres, input logic [31:0] bytes);
    int         n;
    logic [7:0] res [4];
    logic [7:0] typed [4];
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_symbol <= sym;
    in_code_len <= len;
    in_code_bits <= bits;
    do @(posedge clk); while (in_stall);
    pack_symbol(op, sym, len, bits, n, res);
    if (nres < 0) begin
      push_bytes(n, res);
    end else begin
      for (int k = 0; k < 4; k++) typed[k] = (k < nres) ? bytes[8 * (nres - 1 - k) +: 8] : '0;
      push_bytes(nres, typed);
    end
  endtask

  function automatic logic [5:0] rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 6'($urandom_range(12, 1));
    if (r < 95) return 6'($urandom_range(32, 13));
    return 6'($urandom_range(63));
  endfunction

  function automatic logic [7:0] rand_sym();
    return ($urandom_range(99) < 85) ? sym_pool[$urandom_range(15)] : 8'($urandom_range(255));
  endfunction

  task automatic run_random(input int count);
    int           sent;
    int           r;
    pfx_pkg::op_t op;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      if (r < 14) op = pfx_pkg::OP_LOAD;
      else if (r < 86) op = pfx_pkg::OP_ENCODE;
      else if (r < 96) op = pfx_pkg::OP_FLUSH;
      else op = pfx_pkg::OP_NONE;
      send_item(op, rand_sym(), rand_len(), $urandom(), -1, 32'h0);
      sent++;
    end
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    packed_byte_t exp_b;
    if (rst_n && out_valid && !out_stall) begin
      if (byte_queue.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte %02h last %0b", out_byte, out_last));
      end else begin
        exp_b = byte_queue.pop_front();
        if (out_byte !== exp_b.val)
          flag_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, exp_b.val));
        if (out_last !== exp_b.last)
          flag_mismatch($sformatf("out_last %0b, expected %0b", out_last, exp_b.last));
      end
    end
  end

  initial begin
    for (int i = 0; i < 256; i++) begin
      code_len_tbl[i] = '0;
      code_word_tbl[i] = '0;
    end
    held_bits = '0;
    held_cnt = '0;
    for (int i = 0; i < 16; i++) sym_pool[i] = 8'($urandom_range(255));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(dir_rows[i].op, dir_rows[i].sym, dir_rows[i].len, dir_rows[i].bits,
                dir_rows[i].nres, dir_rows[i].bytes);

    for (int i = 0; i < 16; i++)
      send_item(pfx_pkg::OP_LOAD, sym_pool[i], rand_len(), $urandom(), -1, 32'h0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      run_random((RAND_ITEMS - DIR_ROWS - 16) / 4);
    end
    send_item(pfx_pkg::OP_FLUSH, 8'h00, 6'd0, 32'h0, -1, 32'h0);
    in_valid <= 1'b0;

    while (byte_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ prefix_code_bit_packer.f @@
design/pfx_pkg.sv
design/pfx_ctrl.sv
design/pfx_dp.sv
design/prefix_code_bit_packer.sv
design/pfx_chk.sv
bench/prefix_code_bit_packer_tb.sv
